/* hw/rtl/mpd_pkg.sv */
// Package for the minimum pairwise disparity set block.
// Holds the shared widths, command and status codes, and the compare unit control struct.
// No dependencies.
package mpd_pkg;

  localparam int DEF_MAX_ITEMS = 256;
  localparam int DEF_FRAC_BITS = 15;

  localparam int CMD_W    = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 3'd0,
    CMD_QADD  = 3'd1,
    CMD_ADD   = 3'd2,
    CMD_QREM  = 3'd3,
    CMD_REM   = 3'd4,
    CMD_CLEAR = 3'd5,
    CMD_VALUE = 3'd6
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  // Control of the shared disparity/minimum unit.
  typedef struct packed {
    logic start;     // load the running minimum with its seed
    logic seed_one;  // seed with one instead of the current set value
    logic sample;    // a kernel word is present this cycle
  } min_ctl_t;

endpackage

/* hw/rtl/mpd_cmd_if.sv */
// Request channel interface for the minimum pairwise disparity set block.
// Depends on mpd_pkg for the command width.
interface mpd_cmd_if #(
  parameter int IDX_W = 8,
  parameter int SIM_W = 16
);
  import mpd_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [IDX_W-1:0]    item_index;
  logic [IDX_W-1:0]    partner_index;
  logic [SIM_W-1:0]    similarity;

  modport source (output valid, command, item_index, partner_index, similarity, input ready);
  modport sink   (input valid, command, item_index, partner_index, similarity, output ready);

endinterface

/* hw/rtl/mpd_res_if.sv */
// Result channel interface for the minimum pairwise disparity set block.
// Depends on mpd_pkg for the status width.
interface mpd_res_if #(
  parameter int VAL_W = 16
);
  import mpd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [VAL_W-1:0]        set_value;
  logic signed [VAL_W:0]   gain;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, set_value, gain, status, input ready);
  modport sink   (input valid, set_value, gain, status, output ready);

endinterface

/* hw/rtl/mpd_min_unit.sv */
// Shared disparity and running-minimum unit.
// Turns a kernel word into one minus similarity and keeps the smallest seen; uses mpd_pkg.
module mpd_min_unit #(
  parameter int FRAC_BITS = mpd_pkg::DEF_FRAC_BITS,
  localparam int VW = FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  mpd_pkg::min_ctl_t  ctl_i,
  input  logic [VW-1:0]      cur_value_i,
  input  logic [VW-1:0]      kernel_i,
  output logic [VW-1:0]      best_o
);
  import mpd_pkg::*;

  localparam logic [VW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [VW-1:0] best_q, best_d;
  logic [VW-1:0] disp;

  // A saturated kernel word of one or more gives zero disparity.
  assign disp = (kernel_i >= ONE) ? '0 : ONE - kernel_i;

  always_comb begin
    best_d = best_q;
    if (ctl_i.start) begin
      best_d = ctl_i.seed_one ? ONE : cur_value_i;
    end else if (ctl_i.sample && (disp < best_q)) begin
      best_d = disp;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
  end

  assign best_o = best_q;

endmodule

/* hw/rtl/mpd_seq.sv */
// Sequencer of the minimum pairwise disparity set block.
// Holds the kernel memory, membership bits and set value, and walks members through mpd_min_unit.
module mpd_seq #(
  parameter int MAX_ITEMS = mpd_pkg::DEF_MAX_ITEMS,
  parameter int FRAC_BITS = mpd_pkg::DEF_FRAC_BITS,
  localparam int IDX_W = $clog2(MAX_ITEMS),
  localparam int VW = FRAC_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mpd_pkg::CMD_W-1:0]   command_i,
  input  logic [IDX_W-1:0]            item_i,
  input  logic [IDX_W-1:0]            partner_i,
  input  logic [VW-1:0]               similarity_i,
  input  logic [IDX_W:0]              items_in_use_i,
  input  logic                        res_free_i,
  output logic                        idle_o,
  output logic                        done_o,
  output logic [VW-1:0]               set_value_o,
  output logic signed [VW:0]          gain_o,
  output logic [mpd_pkg::STATUS_W-1:0] status_o
);
  import mpd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_FIN   = 4'b1000
  } seq_state_e;

  localparam int              MEM_DEPTH = 1 << (2 * IDX_W);
  localparam logic [IDX_W-1:0] LAST     = IDX_W'(MAX_ITEMS - 1);
  localparam logic [VW-1:0]    ONE      = {1'b1, {FRAC_BITS{1'b0}}};

  seq_state_e             state_q, state_d;
  logic [MAX_ITEMS-1:0]   member_q, member_d;
  logic [VW-1:0]          cur_q, cur_d;
  logic [IDX_W-1:0]       row_q, row_d, col_q, col_d;
  logic [CMD_W-1:0]       cmd_q;
  logic [IDX_W-1:0]       item_q;
  status_e                status_q, status_d;
  logic                   scanned_q, scanned_d;
  logic                   add_mode_q, add_mode_d;
  logic                   skip_en_q, skip_en_d;
  logic                   sample_q;

  logic [VW-1:0]          kmem [MEM_DEPTH];
  logic [VW-1:0]          rd_data_q;
  logic                   wr_en;
  logic [2*IDX_W-1:0]     wr_addr, rd_addr;
  logic [VW-1:0]          wr_data;
  logic                   issue;

  logic                   item_in, partner_in;
  logic                   row_ok, row_last, col_last;
  logic [VW-1:0]          best;
  logic [VW-1:0]          new_val;
  logic signed [VW:0]     gain;
  min_ctl_t               min_ctl;

  assign item_in    = {1'b0, item_i} < items_in_use_i;
  assign partner_in = {1'b0, partner_i} < items_in_use_i;

  // Kernel writes happen at the accepting edge, before any scan reads.
  assign wr_en   = start_i && (command_i == CMD_LOAD) && item_in && partner_in;
  assign wr_addr = {item_i, partner_i};
  assign wr_data = (similarity_i > ONE) ? ONE : similarity_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      kmem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_data_q <= kmem[rd_addr];
    end
  end

  // Scan addressing: an add walks one kernel column against every member,
  // a pair minimum walks member rows by member columns and passes over each
  // non-member row, and for a remove the item's own row, as a whole.
  assign row_last = (row_q == LAST);
  assign col_last = (col_q == LAST);
  assign row_ok   = member_q[row_q] && !(skip_en_q && (row_q == item_q));

  always_comb begin
    if (add_mode_q) begin
      rd_addr = {row_q, item_q};
      issue   = (state_q == S_SCAN) && member_q[row_q] && (row_q != item_q);
    end else begin
      rd_addr = {row_q, col_q};
      issue   = (state_q == S_SCAN) && row_ok && member_q[col_q] && (col_q != row_q) &&
                !(skip_en_q && (col_q == item_q));
    end
  end

  assign min_ctl.start    = start_i;
  assign min_ctl.seed_one = !((command_i == CMD_QADD) || (command_i == CMD_ADD));
  assign min_ctl.sample   = sample_q;

  mpd_min_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_min (
    .clk_i       (clk_i),
    .ctl_i       (min_ctl),
    .cur_value_i (cur_q),
    .kernel_i    (rd_data_q),
    .best_o      (best)
  );

  // Result of the finished request.
  always_comb begin
    new_val = cur_q;
    gain    = '0;
    if (status_q == ST_OK) begin
      unique case (cmd_q)
        CMD_LOAD: begin
          if (scanned_q) begin
            new_val = best;
          end
        end
        CMD_QADD: begin
          gain = $signed({1'b0, best}) - $signed({1'b0, cur_q});
        end
        CMD_ADD: begin
          gain    = $signed({1'b0, best}) - $signed({1'b0, cur_q});
          new_val = best;
        end
        CMD_QREM: begin
          gain = $signed({1'b0, cur_q}) - $signed({1'b0, best});
        end
        CMD_REM: begin
          gain    = $signed({1'b0, cur_q}) - $signed({1'b0, best});
          new_val = best;
        end
        CMD_CLEAR: begin
          new_val = ONE;
        end
        default: begin
          new_val = cur_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    col_d      = col_q;
    status_d   = status_q;
    scanned_d  = scanned_q;
    add_mode_d = add_mode_q;
    skip_en_d  = skip_en_q;
    member_d   = member_q;
    cur_d      = cur_q;
    done_o     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          row_d      = '0;
          col_d      = '0;
          status_d   = ST_OK;
          scanned_d  = 1'b0;
          add_mode_d = 1'b0;
          skip_en_d  = 1'b0;
          state_d    = S_FIN;
          unique case (command_i)
            CMD_LOAD: begin
              if (!item_in || !partner_in) begin
                status_d = ST_RANGE;
              end else if ((item_i != partner_i) && member_q[item_i] && member_q[partner_i]) begin
                scanned_d = 1'b1;
                state_d   = S_SCAN;
              end
            end
            CMD_QADD, CMD_ADD: begin
              if (!item_in) begin
                status_d = ST_RANGE;
              end else if (member_q[item_i]) begin
                status_d = ST_MISMATCH;
              end else begin
                scanned_d  = 1'b1;
                add_mode_d = 1'b1;
                state_d    = S_SCAN;
              end
            end
            CMD_QREM, CMD_REM: begin
              if (!item_in) begin
                status_d = ST_RANGE;
              end else if (!member_q[item_i]) begin
                status_d = ST_MISMATCH;
              end else begin
                scanned_d = 1'b1;
                skip_en_d = 1'b1;
                state_d   = S_SCAN;
              end
            end
            default: begin
              state_d = S_FIN;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (add_mode_q || !row_ok || col_last) begin
          col_d = '0;
          if (row_last) begin
            state_d = S_DRAIN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_free_i) begin
          done_o  = 1'b1;
          cur_d   = new_val;
          state_d = S_IDLE;
          if (status_q == ST_OK) begin
            if (cmd_q == CMD_ADD) begin
              member_d[item_q] = 1'b1;
            end else if (cmd_q == CMD_REM) begin
              member_d[item_q] = 1'b0;
            end else if (cmd_q == CMD_CLEAR) begin
              member_d = '0;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      member_q   <= '0;
      cur_q      <= ONE;
      row_q      <= '0;
      col_q      <= '0;
      status_q   <= ST_OK;
      scanned_q  <= 1'b0;
      add_mode_q <= 1'b0;
      skip_en_q  <= 1'b0;
      sample_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      member_q   <= member_d;
      cur_q      <= cur_d;
      row_q      <= row_d;
      col_q      <= col_d;
      status_q   <= status_d;
      scanned_q  <= scanned_d;
      add_mode_q <= add_mode_d;
      skip_en_q  <= skip_en_d;
      sample_q   <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q  <= command_i;
      item_q <= item_i;
    end
  end

  assign idle_o      = (state_q == S_IDLE);
  assign set_value_o = new_val;
  assign gain_o      = gain;
  assign status_o    = status_q;

endmodule

/* hw/rtl/min_pairwise_disparity_set.sv */
// Top level of the minimum pairwise disparity set block.
// Uses mpd_pkg, mpd_cmd_if, mpd_res_if and mpd_seq (which holds mpd_min_unit).
//
//   Channel  | Direction | Contents
//   ---------+-----------+-----------------------------------------------------
//   cmd_i    | in        | command, item_index, partner_index, similarity
//   res_o    | out       | set_value, gain, status (one result per request)
//   cfg      | in        | cfg_we_i / cfg_wdata_i write items_in_use
//
// A load that needs no recompute, a clear, a read and any rejected request go
// from acceptance straight to the final step. An add or add query walks every
// item slot once through the single kernel memory read port. A remove, remove
// query or a load between two members rebuilds the pairwise minimum: a skipped
// row (a non-member, or the item being removed) is passed over whole, and every
// other member row walks all MAX_ITEMS columns. Reset is asynchronous and active
// low; it clears the set and the set value to one but leaves kernel contents
// undefined. A stalled result holds the block in its final step; the next
// request is taken once the result moves.
module min_pairwise_disparity_set #(
  parameter int MAX_ITEMS = mpd_pkg::DEF_MAX_ITEMS,
  parameter int FRAC_BITS = mpd_pkg::DEF_FRAC_BITS,
  localparam int IDX_W = $clog2(MAX_ITEMS),
  localparam int VW = FRAC_BITS + 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mpd_cmd_if.sink            cmd_i,
  mpd_res_if.source          res_o,
  input  logic               cfg_we_i,
  input  logic [IDX_W:0]     cfg_wdata_i
);
  import mpd_pkg::*;

  localparam logic [IDX_W:0] MAX_CNT  = (IDX_W + 1)'(MAX_ITEMS);
  localparam logic [IDX_W:0] MIN_CNT  = (IDX_W + 1)'(2);
  localparam logic [IDX_W:0] RST_CNT  = (IDX_W + 1)'((MAX_ITEMS < 256) ? MAX_ITEMS : 256);
  localparam logic [VW-1:0]  ONE      = {1'b1, {FRAC_BITS{1'b0}}};

  logic [IDX_W:0]        items_q, items_d;
  logic                  accept;
  logic                  idle;
  logic                  seq_done;
  logic                  res_free;
  logic                  res_valid_q;
  logic [VW-1:0]         res_value_q, seq_value;
  logic signed [VW:0]    res_gain_q, seq_gain;
  logic [STATUS_W-1:0]   res_status_q, seq_status;

  // The item count register clamps writes into the legal range.
  always_comb begin
    if (cfg_wdata_i < MIN_CNT) begin
      items_d = MIN_CNT;
    end else if (cfg_wdata_i > MAX_CNT) begin
      items_d = MAX_CNT;
    end else begin
      items_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      items_q <= RST_CNT;
    end else if (cfg_we_i) begin
      items_q <= items_d;
    end
  end

  // One request is in flight at a time; the sequencer is ready only when idle.
  assign cmd_i.ready = idle;
  assign accept      = cmd_i.valid && cmd_i.ready;

  // The output register is free when empty or when its result leaves now.
  assign res_free = !res_valid_q || res_o.ready;

  mpd_seq #(
    .MAX_ITEMS (MAX_ITEMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (accept),
    .command_i      (cmd_i.command),
    .item_i         (cmd_i.item_index),
    .partner_i      (cmd_i.partner_index),
    .similarity_i   (cmd_i.similarity),
    .items_in_use_i (items_q),
    .res_free_i     (res_free),
    .idle_o         (idle),
    .done_o         (seq_done),
    .set_value_o    (seq_value),
    .gain_o         (seq_gain),
    .status_o       (seq_status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (seq_done) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      res_value_q  <= seq_value;
      res_gain_q   <= seq_gain;
      res_status_q <= seq_status;
    end
  end

  assign res_o.valid     = res_valid_q;
  assign res_o.set_value = res_value_q;
  assign res_o.gain      = res_gain_q;
  assign res_o.status    = res_status_q;

  // Once a request is taken, no second one is taken on the next edge.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !cmd_i.ready)
    else $error("request accepted while another was in flight");

  // The sequencer only finishes into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_done |-> res_free)
    else $error("result overwrote a pending result");

  // Rejected requests carry no gain.
  a_reject_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status != ST_OK)) |-> (res_o.gain == '0))
    else $error("rejected request reported a nonzero gain");

  // The set value never exceeds one.
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.set_value <= ONE))
    else $error("set value above one");

endmodule
